FILE: hw/rtl/fcdma_pkg.sv
package fcdma_pkg;

    // Channel geometry.
    localparam int CHANNELS   = 4;
    localparam int CH_IDX_W   = 2;
    localparam int WORD_W     = 16;
    localparam int COUNT_W    = 14;

    // Register map and mode/status bit positions.
    localparam logic [3:0]   MODE_OFFSET    = 4'd8;
    localparam int           TC_STOP_BIT    = 6;
    localparam logic [7:0]   STATUS_TC_MASK = 8'h0F;
    localparam logic [7:0]   UNMAPPED_READ  = 8'hFF;
    localparam logic [1:0]   DIR_TO_MEMORY  = 2'b01;
    localparam logic [COUNT_W-1:0] COUNT_WRAP = 14'h3FFF;

    // Bus commands; the fourth code is a no-operation.
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_XFER  = 2'd2
    } t_cmd;

    // One accepted bus item.
    typedef struct packed {
        t_cmd       cmd;
        logic [3:0] port_offset;
        logic [7:0] write_data;
    } t_item;

    // One result item.
    typedef struct packed {
        logic [7:0]          read_data;
        logic                channel_valid;
        logic [CH_IDX_W-1:0] channel_index;
        logic [WORD_W-1:0]   current_address;
        logic                to_memory;
        logic                last_terminal_count;
    } t_result;

endpackage

FILE: hw/rtl/fcdma_core.sv
module fcdma_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  fcdma_pkg::t_item  i_item,
    output fcdma_pkg::t_result o_result
);
    import fcdma_pkg::*;

    logic [WORD_W-1:0]   r_addr  [CHANNELS];
    logic [WORD_W-1:0]   n_addr  [CHANNELS];
    logic [WORD_W-1:0]   r_count [CHANNELS];
    logic [WORD_W-1:0]   n_count [CHANNELS];
    logic [7:0]          r_mode;
    logic [7:0]          n_mode;
    logic [7:0]          r_status;
    logic [7:0]          n_status;
    logic                r_byte_high;
    logic                n_byte_high;
    logic                r_tc;
    logic                n_tc;

    logic                act_valid;
    logic [CH_IDX_W-1:0] act_idx;
    logic [CH_IDX_W-1:0] reg_sel;
    logic                is_count;
    logic [WORD_W-1:0]   sel_word;
    logic [WORD_W-1:0]   new_word;
    logic [COUNT_W-1:0]  act_rem;
    logic [7:0]          rd;

    // Fixed priority: the lowest enabled channel wins.
    always_comb begin
        act_valid = |r_mode[CHANNELS-1:0];
        act_idx   = '0;
        for (int k = CHANNELS - 1; k >= 0; k--) begin
            if (r_mode[k]) begin
                act_idx = CH_IDX_W'(k);
            end
        end
    end

    // Byte access decode and the word it reaches.
    assign reg_sel  = i_item.port_offset[CH_IDX_W:1];
    assign is_count = i_item.port_offset[0];
    assign sel_word = is_count ? r_count[reg_sel] : r_addr[reg_sel];
    assign new_word = r_byte_high ? {i_item.write_data, sel_word[7:0]}
                                  : {sel_word[15:8], i_item.write_data};
    assign act_rem  = r_count[act_idx][COUNT_W-1:0];

    // Next state and read data for the item in hand.
    always_comb begin
        n_addr      = r_addr;
        n_count     = r_count;
        n_mode      = r_mode;
        n_status    = r_status;
        n_byte_high = r_byte_high;
        n_tc        = r_tc;
        rd          = '0;
        case (i_item.cmd)
            CMD_WRITE: begin
                if (i_item.port_offset == MODE_OFFSET) begin
                    n_mode      = i_item.write_data;
                    n_byte_high = 1'b0;
                end else if (!i_item.port_offset[3]) begin
                    if (is_count) begin
                        n_count[reg_sel] = new_word;
                    end else begin
                        n_addr[reg_sel] = new_word;
                    end
                    n_byte_high = !r_byte_high;
                end
            end
            CMD_READ: begin
                if (i_item.port_offset == MODE_OFFSET) begin
                    rd       = r_status;
                    n_status = r_status & ~STATUS_TC_MASK;
                end else if (i_item.port_offset[3]) begin
                    rd = UNMAPPED_READ;
                end else begin
                    rd          = r_byte_high ? sel_word[15:8] : sel_word[7:0];
                    n_byte_high = !r_byte_high;
                end
            end
            CMD_XFER: begin
                n_tc = 1'b0;
                if (act_valid) begin
                    n_addr[act_idx] = r_addr[act_idx] + 1'b1;
                    if (act_rem == '0) begin
                        n_tc              = 1'b1;
                        n_status[act_idx] = 1'b1;
                        if (r_mode[TC_STOP_BIT]) begin
                            n_mode[act_idx] = 1'b0;
                        end
                        n_count[act_idx] = {r_count[act_idx][WORD_W-1:COUNT_W], COUNT_WRAP};
                    end else begin
                        n_count[act_idx] = {r_count[act_idx][WORD_W-1:COUNT_W],
                                            act_rem - 1'b1};
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // The channel fields describe the state before this item.
    always_comb begin
        o_result.read_data           = rd;
        o_result.channel_valid       = act_valid;
        o_result.channel_index       = act_idx;
        o_result.current_address     = act_valid ? r_addr[act_idx] : '0;
        o_result.to_memory           = act_valid &&
                                       (r_count[act_idx][WORD_W-1:COUNT_W] == DIR_TO_MEMORY);
        o_result.last_terminal_count = n_tc;
    end

    // Register file update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CHANNELS; k++) begin
                r_addr[k]  <= '0;
                r_count[k] <= '0;
            end
            r_mode      <= '0;
            r_status    <= '0;
            r_byte_high <= 1'b0;
            r_tc        <= 1'b0;
        end else if (i_en) begin
            r_addr      <= n_addr;
            r_count     <= n_count;
            r_mode      <= n_mode;
            r_status    <= n_status;
            r_byte_high <= n_byte_high;
            r_tc        <= n_tc;
        end
    end

endmodule

FILE: hw/rtl/four_channel_dma_register_controller.sv
// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tuser: command; tdata: offset, byte
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata: read byte, channel state, TC flag
//
// One item is taken each clock while the result side does not stall; each item
// gives one result, passing through the input register and then the result register.
// The register file is updated as an item moves from the input register into
// the result register, so consecutive items see each other's effects.
// Reset (synchronous, active low) clears all channel, mode and status registers.
// A stalled result holds the item in the input register, and input is then
// refused until the result is taken.
module four_channel_dma_register_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [3:0] port_offset, [11:4] write_data, [15:12] zero
    input  logic [1:0]  s_axis_tuser,  // [1:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // [7:0] read_data, [8] channel_valid,
                                       // [10:9] channel_index, [26:11] current_address,
                                       // [27] to_memory, [28] last_terminal_count,
                                       // [31:29] zero
);
    import fcdma_pkg::*;

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out;
    t_result core_result;
    logic    advance;

    // The item moves on when the result register is free or being emptied.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item.cmd         <= t_cmd'(s_axis_tuser);
            r_in_item.port_offset <= s_axis_tdata[3:0];
            r_in_item.write_data  <= s_axis_tdata[11:4];
        end
    end

    fcdma_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_item   (r_in_item),
        .o_result (core_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000,
                            r_out.last_terminal_count,
                            r_out.to_memory,
                            r_out.current_address,
                            r_out.channel_index,
                            r_out.channel_valid,
                            r_out.read_data};

`ifndef SYNTH
    // A held item is neither lost nor altered while the result side stalls.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_item)))
        else $error("input item lost or changed while stalled");

    // A result taken with nothing behind it leaves the output empty.
    a_out_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && m_axis_tready && !advance) |=> !r_out_valid)
        else $error("result repeated after transfer");

    // With no enabled channel the channel fields read as zero.
    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.channel_valid) |->
        (r_out.channel_index == '0 && r_out.current_address == '0 && !r_out.to_memory))
        else $error("channel fields set with no active channel");
`endif

endmodule
